[rtl/cached_view_vertex_transform_macros.svh]
`ifndef CACHED_VIEW_VERTEX_TRANSFORM_MACROS_SVH
`define CACHED_VIEW_VERTEX_TRANSFORM_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CVVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvvt assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define CVVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvvt assertion failed");

`endif

[rtl/cvvt_pkg.sv]
`default_nettype none

package cvvt_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SLOT_W  = 16;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned VIEW_W  = 24;
    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAMERA_X  = 3'd0,
        REG_CAMERA_Y  = 3'd1,
        REG_FORWARD_X = 3'd2,
        REG_FORWARD_Y = 3'd3,
        REG_RIGHT_X   = 3'd4,
        REG_RIGHT_Y   = 3'd5,
        REG_PASS_TAG  = 3'd6
    } cvvt_reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] forward_x;
        logic signed [COORD_W-1:0] forward_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic        [TAG_W-1:0]   pass_tag;
    } cvvt_cfg_t;

endpackage

`default_nettype wire

[rtl/cvvt_vertex_if.sv]
`default_nettype none

interface cvvt_vertex_if
    import cvvt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic        [SLOT_W-1:0]  vertex_slot;
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;

    modport source (output valid, output vertex_slot, output world_x, output world_y,
                    input ready);
    modport sink   (input valid, input vertex_slot, input world_x, input world_y,
                    output ready);
endinterface

`default_nettype wire

[rtl/cvvt_view_if.sv]
`default_nettype none

interface cvvt_view_if
    import cvvt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [VIEW_W-1:0] view_depth;
    logic signed [VIEW_W-1:0] view_lateral;

    modport source (output valid, output view_depth, output view_lateral, input ready);
    modport sink   (input valid, input view_depth, input view_lateral, output ready);
endinterface

`default_nettype wire

[rtl/cvvt_cfg_if.sv]
`default_nettype none

interface cvvt_cfg_if
    import cvvt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/cached_view_vertex_transform.sv]
// a vertex beat is registered in the input stage, then in the result register, before its view beat is offered
// throughput: one vertex per cycle while the view side is ready; a stall there holds vertex
// cache lookup uses a registered read of the tag, depth and lateral memories
// reset: asynchronous active low; registers return to defaults (pass_tag = 1)
// after reset the tag memory is swept to zero, every slot in turn, with vertex ready low
`default_nettype none

`include "cached_view_vertex_transform_macros.svh"

module cached_view_vertex_transform
    import cvvt_pkg::*;
#(
    parameter int unsigned VERTEX_SLOTS = 1024,
    parameter int unsigned FRAC_BITS    = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cvvt_cfg_if.sink    cfg,
    cvvt_vertex_if.sink vertex,
    cvvt_view_if.source view
);

    localparam int unsigned ADDR_W = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int unsigned SLOT_CMP_W = SLOT_W + 1;

    cvvt_cfg_t regs;

    logic                      clearing_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;

    logic                      s1_valid_reg;
    logic [SLOT_W-1:0]         s1_slot_reg;
    logic signed [COORD_W-1:0] s1_wx_reg;
    logic signed [COORD_W-1:0] s1_wy_reg;
    logic                      s1_in_range_reg;
    logic                      fwd_hit_reg;
    logic [COORD_W-1:0]        fwd_depth_reg;
    logic [COORD_W-1:0]        fwd_lateral_reg;

    logic                      out_valid_reg;
    logic signed [VIEW_W-1:0]  out_depth_reg;
    logic signed [VIEW_W-1:0]  out_lateral_reg;

    logic                      accept;
    logic                      s1_go;
    logic                      in_range;
    logic                      hit;
    logic                      s1_write;
    logic [TAG_W-1:0]          tag_rd;
    logic [COORD_W-1:0]        depth_rd;
    logic [COORD_W-1:0]        lateral_rd;
    logic signed [COORD_W-1:0] hit_depth;
    logic signed [COORD_W-1:0] hit_lateral;
    logic signed [VIEW_W-1:0]  fresh_depth;
    logic signed [VIEW_W-1:0]  fresh_lateral;
    logic signed [VIEW_W-1:0]  res_depth;
    logic signed [VIEW_W-1:0]  res_lateral;
    logic                      tag_we;
    logic [ADDR_W-1:0]         tag_waddr;
    logic [TAG_W-1:0]          tag_wdata;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;

    cvvt_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cvvt_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .regs    (regs),
        .world_x (s1_wx_reg),
        .world_y (s1_wy_reg),
        .depth   (fresh_depth),
        .lateral (fresh_lateral)
    );

    // handshake and stage control
    assign s1_go        = s1_valid_reg && (!out_valid_reg || view.ready);
    assign vertex.ready = !clearing_reg && (!s1_valid_reg || s1_go);
    assign accept       = vertex.valid && vertex.ready;
    assign in_range     = SLOT_CMP_W'(vertex.vertex_slot) < SLOT_CMP_W'(VERTEX_SLOTS);
    assign rd_addr      = vertex.vertex_slot[ADDR_W-1:0];
    assign wr_addr      = s1_slot_reg[ADDR_W-1:0];

    // hit either from memory or forwarded from the beat ahead that used the same slot
    assign hit         = s1_in_range_reg && (fwd_hit_reg || tag_rd == regs.pass_tag);
    assign hit_depth   = fwd_hit_reg ? fwd_depth_reg : depth_rd;
    assign hit_lateral = fwd_hit_reg ? fwd_lateral_reg : lateral_rd;
    assign res_depth   = hit ? VIEW_W'(hit_depth) : fresh_depth;
    assign res_lateral = hit ? VIEW_W'(hit_lateral) : fresh_lateral;
    assign s1_write    = s1_go && s1_in_range_reg && !hit;

    assign tag_we    = clearing_reg || s1_write;
    assign tag_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign tag_wdata = clearing_reg ? '0 : regs.pass_tag;

    cvvt_ram #(
        .WIDTH (TAG_W),
        .DEPTH (VERTEX_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (tag_rd)
    );

    cvvt_ram #(
        .WIDTH (COORD_W),
        .DEPTH (VERTEX_SLOTS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (s1_write),
        .waddr (wr_addr),
        .wdata (res_depth[COORD_W-1:0]),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (depth_rd)
    );

    cvvt_ram #(
        .WIDTH (COORD_W),
        .DEPTH (VERTEX_SLOTS)
    ) u_lateral_ram (
        .clk   (clk),
        .we    (s1_write),
        .waddr (wr_addr),
        .wdata (res_lateral[COORD_W-1:0]),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (lateral_rd)
    );

    // tag clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(VERTEX_SLOTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg     <= vertex.vertex_slot;
            s1_wx_reg       <= vertex.world_x;
            s1_wy_reg       <= vertex.world_y;
            s1_in_range_reg <= in_range;
            fwd_hit_reg     <= s1_valid_reg && s1_in_range_reg
                               && s1_slot_reg == vertex.vertex_slot;
            fwd_depth_reg   <= res_depth[COORD_W-1:0];
            fwd_lateral_reg <= res_lateral[COORD_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (view.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_depth_reg   <= res_depth;
            out_lateral_reg <= res_lateral;
        end
    end

    assign view.valid        = out_valid_reg;
    assign view.view_depth   = out_depth_reg;
    assign view.view_lateral = out_lateral_reg;

    `CVVT_ASSERT_NOW(a_fwd_in_range, s1_valid_reg && fwd_hit_reg, s1_in_range_reg)
    `CVVT_ASSERT_NEXT(a_go_loads_out, s1_go, out_valid_reg)
    `CVVT_ASSERT_NOW(a_clear_sweep_done, $fell(clearing_reg), clr_addr_reg == '0 || VERTEX_SLOTS != (1 << ADDR_W))
    `CVVT_ASSERT_NOW(a_no_item_in_clear, clearing_reg, !s1_valid_reg && !out_valid_reg)

endmodule

`default_nettype wire

[rtl/cvvt_ram.sv]
`default_nettype none

module cvvt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/cvvt_regs.sv]
`default_nettype none

module cvvt_regs
    import cvvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cvvt_cfg_if.sink   cfg,
    output cvvt_cfg_t  regs
);

    cvvt_cfg_t regs_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{pass_tag: TAG_W'(1), default: '0};
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cvvt_reg_idx_t'(cfg.index))
                REG_CAMERA_X:  regs_reg.camera_x  <= cfg.data;
                REG_CAMERA_Y:  regs_reg.camera_y  <= cfg.data;
                REG_FORWARD_X: regs_reg.forward_x <= cfg.data;
                REG_FORWARD_Y: regs_reg.forward_y <= cfg.data;
                REG_RIGHT_X:   regs_reg.right_x   <= cfg.data;
                REG_RIGHT_Y:   regs_reg.right_y   <= cfg.data;
                REG_PASS_TAG:  regs_reg.pass_tag  <= cfg.data;
                default:       regs_reg           <= regs_reg;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

[rtl/cvvt_xform.sv]
`default_nettype none

module cvvt_xform
    import cvvt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire cvvt_cfg_t            regs,
    input  wire logic signed [COORD_W-1:0] world_x,
    input  wire logic signed [COORD_W-1:0] world_y,
    output logic signed [VIEW_W-1:0]  depth,
    output logic signed [VIEW_W-1:0]  lateral
);

    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned SUM_W  = PROD_W + 1;

    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [PROD_W-1:0]  prod_fx;
    logic signed [PROD_W-1:0]  prod_fy;
    logic signed [PROD_W-1:0]  prod_rx;
    logic signed [PROD_W-1:0]  prod_ry;
    logic signed [SUM_W-1:0]   sum_depth;
    logic signed [SUM_W-1:0]   sum_lateral;
    logic signed [SUM_W-1:0]   shr_depth;
    logic signed [SUM_W-1:0]   shr_lateral;

    always_comb
    begin
        // camera-relative position, wrapped to 16 bits
        rel_x       = world_x - regs.camera_x;
        rel_y       = world_y - regs.camera_y;
        prod_fx     = PROD_W'(rel_x) * PROD_W'(regs.forward_x);
        prod_fy     = PROD_W'(rel_y) * PROD_W'(regs.forward_y);
        prod_rx     = PROD_W'(rel_x) * PROD_W'(regs.right_x);
        prod_ry     = PROD_W'(rel_y) * PROD_W'(regs.right_y);
        sum_depth   = SUM_W'(prod_fx) + SUM_W'(prod_fy);
        sum_lateral = SUM_W'(prod_rx) + SUM_W'(prod_ry);
        shr_depth   = sum_depth >>> FRAC_BITS;
        shr_lateral = sum_lateral >>> FRAC_BITS;
        depth       = shr_depth[VIEW_W-1:0];
        lateral     = shr_lateral[VIEW_W-1:0];
    end

endmodule

`default_nettype wire

[tb/cached_view_vertex_transform_test.sv]
`timescale 1ns / 100ps

module cached_view_vertex_transform_test;
    import cvvt_pkg::*;

    localparam int unsigned SLOTS = 1024;
    localparam int unsigned FRAC = 8;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [VIEW_W-1:0] depth;
        logic [VIEW_W-1:0] lateral;
    } view_beat_t;

    class view_scoreboard;
        cvvt_cfg_t settings;
        logic [TAG_W-1:0] tag_mem[SLOTS];
        logic [15:0] depth_mem[SLOTS];
        logic [15:0] lateral_mem[SLOTS];
        bit written[SLOTS];
        int written_list[$];
        view_beat_t pending_views[$];
        int failures;
        int beats_seen;

        function new();
            settings = '0;
            settings.pass_tag = 16'd1;
            foreach (tag_mem[i]) tag_mem[i] = '0;
            failures = 0;
            beats_seen = 0;
        endfunction

        function void apply_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
            case (idx)
                REG_CAMERA_X:  settings.camera_x = value;
                REG_CAMERA_Y:  settings.camera_y = value;
                REG_FORWARD_X: settings.forward_x = value;
                REG_FORWARD_Y: settings.forward_y = value;
                REG_RIGHT_X:   settings.right_x = value;
                REG_RIGHT_Y:   settings.right_y = value;
                REG_PASS_TAG:  settings.pass_tag = value;
                default: ;
            endcase
        endfunction

        // two signed products summed exactly, arithmetic shift, keep low bits
        function logic [VIEW_W-1:0] project_axis(logic signed [COORD_W-1:0] dx,
                                                 logic signed [COORD_W-1:0] dy,
                                                 logic signed [COORD_W-1:0] kx,
                                                 logic signed [COORD_W-1:0] ky);
            longint total;
            total = longint'(dx) * longint'(kx) + longint'(dy) * longint'(ky);
            total = total >>> FRAC;
            return total[VIEW_W-1:0];
        endfunction

        function void note_vertex(logic [SLOT_W-1:0] slot, logic signed [COORD_W-1:0] wx,
                                  logic signed [COORD_W-1:0] wy);
            logic signed [COORD_W-1:0] dx;
            logic signed [COORD_W-1:0] dy;
            view_beat_t beat;
            bit in_range;
            in_range = slot < SLOTS;
            if (in_range && tag_mem[slot] == settings.pass_tag)
            begin
                beat.depth = {{(VIEW_W-16){depth_mem[slot][15]}}, depth_mem[slot]};
                beat.lateral = {{(VIEW_W-16){lateral_mem[slot][15]}}, lateral_mem[slot]};
            end
            else
            begin
                dx = wx - settings.camera_x;
                dy = wy - settings.camera_y;
                beat.depth = project_axis(dx, dy, settings.forward_x, settings.forward_y);
                beat.lateral = project_axis(dx, dy, settings.right_x, settings.right_y);
                if (in_range)
                begin
                    depth_mem[slot] = beat.depth[15:0];
                    lateral_mem[slot] = beat.lateral[15:0];
                    tag_mem[slot] = settings.pass_tag;
                    if (!written[slot])
                    begin
                        written[slot] = 1'b1;
                        written_list.push_back(int'(slot));
                    end
                end
            end
            pending_views.push_back(beat);
        endfunction

        function void check_view(logic [VIEW_W-1:0] depth, logic [VIEW_W-1:0] lateral);
            view_beat_t want;
            beats_seen++;
            if (pending_views.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("view beat %0d unexpected: depth %0d lateral %0d", beats_seen,
                             $signed(depth), $signed(lateral));
                return;
            end
            want = pending_views.pop_front();
            if (want.depth !== depth || want.lateral !== lateral)
            begin
                failures++;
                if (failures <= 10)
                    $display("view beat %0d: depth exp %0d got %0d, lateral exp %0d got %0d",
                             beats_seen, $signed(want.depth), $signed(depth),
                             $signed(want.lateral), $signed(lateral));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cvvt_cfg_if cfg_bus();
    cvvt_vertex_if vertex_bus();
    cvvt_view_if view_bus();

    cached_view_vertex_transform #(
        .VERTEX_SLOTS(SLOTS),
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .vertex(vertex_bus),
        .view(view_bus)
    );

    view_scoreboard sb = new();
    int burst_left = 0;
    logic [TAG_W-1:0] tag_now = 16'd1;
    logic [TAG_W-1:0] tag_history[$] = '{16'd1};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.apply_reg(cfg_bus.index, cfg_bus.data);
            if (vertex_bus.valid && vertex_bus.ready)
                sb.note_vertex(vertex_bus.vertex_slot, vertex_bus.world_x, vertex_bus.world_y);
            if (view_bus.valid && view_bus.ready)
                sb.check_view(view_bus.view_depth, view_bus.view_lateral);
        end
    end

    // result side back-pressure
    initial
    begin
        int mode;
        int span;
        int tick;
        view_bus.ready <= 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: view_bus.ready <= 1'b1;
                    1: view_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: view_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: view_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((vertex_bus.valid && vertex_bus.ready) || (view_bus.valid && view_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        logic [SLOT_W-1:0] slot;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: slot = SLOT_W'($urandom_range(0, 15));
            5, 6: slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            7:
            begin
                case ($urandom_range(0, 2))
                    0: slot = SLOT_W'(SLOTS - 1);
                    1: slot = SLOT_W'(SLOTS);
                    default: slot = 16'hFFFF;
                endcase
            end
            8: slot = SLOT_W'($urandom_range(SLOTS, 65535));
            default: slot = SLOT_W'($urandom);
        endcase
        // with tag zero an unwritten entry would match its reset tag
        if (tag_now == '0 && slot < SLOTS && !sb.written[slot])
        begin
            if (sb.written_list.size() > 0)
                slot = SLOT_W'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]);
            else
                slot = SLOT_W'(SLOTS);
        end
        return slot;
    endfunction

    task automatic put_vertex(logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] wx,
                              logic [COORD_W-1:0] wy);
        int gap;
        vertex_bus.valid <= 1'b1;
        vertex_bus.vertex_slot <= slot;
        vertex_bus.world_x <= wx;
        vertex_bus.world_y <= wy;
        @(posedge clk);
        while (!vertex_bus.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                vertex_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold the vertex side until every view beat is back
    task automatic settle();
        vertex_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_views.size() > 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        if (idx == REG_PASS_TAG)
        begin
            tag_now = value;
            tag_history.push_back(value);
        end
    endtask

    task automatic random_config();
        logic [TAG_W-1:0] next_tag;
        settle();
        for (int i = REG_CAMERA_X; i <= REG_RIGHT_Y; i++)
            if ($urandom_range(0, 1) == 1)
                write_reg(i[REG_IDX_W-1:0], pick_coord());
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0: next_tag = '0;
                1: next_tag = 16'hFFFF;
                2, 3: next_tag = tag_history[$urandom_range(0, tag_history.size() - 1)];
                4: next_tag = TAG_W'($urandom);
                default: next_tag = tag_now + 16'd1;
            endcase
            write_reg(REG_PASS_TAG, next_tag);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, COORD_W'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        vertex_bus.valid <= 1'b0;
        vertex_bus.vertex_slot <= '0;
        vertex_bus.world_x <= '0;
        vertex_bus.world_y <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero vectors, tag one
        put_vertex(16'd0, 16'sd100, 16'sd200);
        put_vertex(16'd0, 16'hFFFF, 16'hFFFF);
        put_vertex(16'd1024, 16'sd5, 16'sd5);

        // extreme vectors, camera subtraction wraps
        settle();
        write_reg(REG_CAMERA_X, 16'h8000);
        write_reg(REG_CAMERA_Y, 16'h7FFF);
        write_reg(REG_FORWARD_X, 16'h8000);
        write_reg(REG_FORWARD_Y, 16'h7FFF);
        write_reg(REG_RIGHT_X, 16'h7FFF);
        write_reg(REG_RIGHT_Y, 16'h8000);
        write_reg(REG_PASS_TAG, 16'd2);
        write_reg(REG_UNUSED, 16'h1234);
        cfg_bus.valid <= 1'b0;
        put_vertex(16'd0, 16'h7FFF, 16'h8000);
        put_vertex(16'd0, 16'h0000, 16'h0000);
        put_vertex(16'd1023, 16'h8000, 16'h7FFF);
        put_vertex(16'd1024, 16'h7FFF, 16'h7FFF);
        put_vertex(16'hFFFF, 16'h8000, 16'h8000);
        put_vertex(16'hFFFF, 16'h8000, 16'h8000);
        put_vertex(16'd5, 16'h0001, 16'hFFFF);
        put_vertex(16'd1023, 16'h0001, 16'h0001);

        // sums beyond 24 bits, hit returns truncated value
        settle();
        write_reg(REG_CAMERA_X, 16'h0000);
        write_reg(REG_CAMERA_Y, 16'h0000);
        write_reg(REG_FORWARD_X, 16'h8000);
        write_reg(REG_FORWARD_Y, 16'h8000);
        write_reg(REG_RIGHT_X, 16'h7FFF);
        write_reg(REG_RIGHT_Y, 16'h7FFF);
        write_reg(REG_PASS_TAG, 16'hFFFF);
        cfg_bus.valid <= 1'b0;
        put_vertex(16'd7, 16'h8000, 16'h8000);
        put_vertex(16'd7, 16'h0000, 16'h0000);
        put_vertex(16'd8, 16'h7FFF, 16'h7FFF);
        put_vertex(16'd0, 16'h0003, 16'h0004);

        // tag zero on written slots only
        settle();
        write_reg(REG_PASS_TAG, 16'h0000);
        cfg_bus.valid <= 1'b0;
        put_vertex(16'd7, 16'h0001, 16'h0001);
        put_vertex(16'd7, 16'h0002, 16'h0002);
        put_vertex(16'd0, 16'h0005, 16'h0006);
        put_vertex(16'd1024, 16'h0007, 16'h0008);

        for (int phase = 0; phase < 8; phase++)
        begin
            random_config();
            repeat (75)
                put_vertex(pick_slot(), pick_coord(), pick_coord());
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending_views.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
